[rtl/perlin_noise_3d_macros.svh]
// Assertion macros for the 3D noise pipeline.
`ifndef PERLIN_NOISE_3D_MACROS_SVH
`define PERLIN_NOISE_3D_MACROS_SVH
`define PN_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[rtl/pn3d_pkg.sv]
// Package with the permutation table, fixed-point widths and helper functions.
`timescale 1ns / 1ps
`default_nettype none
package pn3d_pkg;
    localparam int unsigned Q = 16;
    localparam int unsigned ONE = 65536;
    localparam int unsigned STAGES = 10;

    typedef logic [7:0] t_byte;
    typedef logic [15:0] t_frac;
    typedef logic signed [19:0] t_val;

    localparam logic [7:0] PERM [256] = '{
        8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
        8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
        8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
        8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
        8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
        8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
        8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
        8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
        8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
        8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
        8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
        8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
        8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
        8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
        8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
        8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
        8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
        8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
        8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
        8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
        8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
        8'd215,8'd61,8'd156,8'd180
    };

    function automatic t_byte perm_lu(input t_byte i);
        return PERM[i];
    endfunction

    // Gradient dot product of a corner, offsets given as signed Q3.16.
    function automatic t_val grad_dot(input logic [3:0] h, input t_val x,
                                      input t_val y, input t_val z);
        t_val u;
        t_val v;
        u = (h < 4'd8) ? x : y;
        v = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
        u = h[0] ? -u : u;
        v = h[1] ? -v : v;
        return u + v;
    endfunction
endpackage
`default_nettype wire

[rtl/perlin_noise_3d.sv]
// Top level of the pipelined 3D improved noise generator.
`timescale 1ns / 1ps
`default_nettype none
`include "perlin_noise_3d_macros.svh"
// Takes one point per cycle and returns one noise value per cycle while the output
// is not stalled. The depth is set by the fade polynomial, which needs three
// multiplies in series, and by the three levels of interpolation that follow it.
// A stalled output holds the whole pipeline, so no word is lost or repeated.
module perlin_noise_3d import pn3d_pkg::*; #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_ready,
    input  wire signed [31:0]  i_coord_x,
    input  wire signed [31:0]  i_coord_y,
    input  wire signed [31:0]  i_coord_z,
    output logic               o_valid,
    input  wire                i_ready,
    output logic signed [17:0] o_noise_value
);
    logic [STAGES-1:0] r_vld;
    logic              adv;

    assign adv     = !r_vld[STAGES-1] || i_ready;
    assign o_ready = adv;
    assign o_valid = r_vld[STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[STAGES-2:0], i_valid};
        end
    end

    function automatic t_frac get_frac(input logic [31:0] c);
        logic [31:0] f;
        f = c & ((32'd1 << FRAC_BITS) - 32'd1);
        if (FRAC_BITS >= Q) begin
            f = f >> (FRAC_BITS - Q);
        end else begin
            f = f << (Q - FRAC_BITS);
        end
        return f[15:0];
    endfunction

    function automatic t_byte get_cell(input logic [31:0] c);
        logic [31:0] s;
        s = c >> FRAC_BITS;
        return s[7:0];
    endfunction

    // Stage 1: split coordinates, first hash level, fade square.
    t_frac  r1_f [3];
    t_byte  r1_c [3];
    t_byte  r1_a, r1_b;
    logic [31:0] r1_t2 [3];
    logic signed [19:0] r1_a6 [3];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_f[0] <= get_frac(i_coord_x);
            r1_f[1] <= get_frac(i_coord_y);
            r1_f[2] <= get_frac(i_coord_z);
            r1_c[0] <= get_cell(i_coord_x);
            r1_c[1] <= get_cell(i_coord_y);
            r1_c[2] <= get_cell(i_coord_z);
            r1_a <= perm_lu(get_cell(i_coord_x));
            r1_b <= perm_lu(get_cell(i_coord_x) + 8'd1);
            for (int k = 0; k < 3; k++) begin
                r1_t2[k] <= 32'(get_frac(k == 0 ? i_coord_x : (k == 1 ? i_coord_y
                    : i_coord_z))) * 32'(get_frac(k == 0 ? i_coord_x
                    : (k == 1 ? i_coord_y : i_coord_z)));
                r1_a6[k] <= 20'sd0;
            end
        end
    end

    // Stage 2: t2 truncated, t3 product, a*f product, second hash level.
    t_frac r2_f [3];
    t_byte r2_cz;
    t_byte r2_aa, r2_ab, r2_ba, r2_bb;
    logic [31:0] r2_t3 [3];
    logic signed [39:0] r2_af [3];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_f <= r1_f;
            r2_cz <= r1_c[2];
            r2_aa <= perm_lu(r1_a + r1_c[1]);
            r2_ab <= perm_lu(r1_a + r1_c[1] + 8'd1);
            r2_ba <= perm_lu(r1_b + r1_c[1]);
            r2_bb <= perm_lu(r1_b + r1_c[1] + 8'd1);
            for (int k = 0; k < 3; k++) begin
                r2_t3[k] <= 32'(r1_t2[k][31:16]) * 32'(r1_f[k]);
                r2_af[k] <= (40'sd6 * $signed({24'd0, r1_f[k]}) - 40'sd983040)
                            * $signed({24'd0, r1_f[k]}) + 40'(r1_a6[k]);
            end
        end
    end

    // Stage 3: b formed, t3 truncated, corner hashes.
    t_frac r3_f [3];
    logic [15:0] r3_t3 [3];
    logic signed [23:0] r3_b [3];
    t_byte r3_h [8];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_f <= r2_f;
            for (int k = 0; k < 3; k++) begin
                r3_t3[k] <= r2_t3[k][31:16];
                r3_b[k]  <= 24'(r2_af[k] >>> 16) + 24'sd655360;
            end
            r3_h[0] <= perm_lu(r2_aa + r2_cz);
            r3_h[1] <= perm_lu(r2_ba + r2_cz);
            r3_h[2] <= perm_lu(r2_ab + r2_cz);
            r3_h[3] <= perm_lu(r2_bb + r2_cz);
            r3_h[4] <= perm_lu(r2_aa + r2_cz + 8'd1);
            r3_h[5] <= perm_lu(r2_ba + r2_cz + 8'd1);
            r3_h[6] <= perm_lu(r2_ab + r2_cz + 8'd1);
            r3_h[7] <= perm_lu(r2_bb + r2_cz + 8'd1);
        end
    end

    // Stage 4: fade product, gradient dots.
    logic signed [40:0] r4_fp [3];
    t_val r4_g [8];
    t_val x0, y0, z0, x1, y1, z1;
    assign x0 = t_val'({4'd0, r3_f[0]});
    assign y0 = t_val'({4'd0, r3_f[1]});
    assign z0 = t_val'({4'd0, r3_f[2]});
    assign x1 = x0 - t_val'(ONE);
    assign y1 = y0 - t_val'(ONE);
    assign z1 = z0 - t_val'(ONE);
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                r4_fp[k] <= $signed({25'd0, r3_t3[k]}) * 41'(r3_b[k]);
            end
            r4_g[0] <= grad_dot(r3_h[0][3:0], x0, y0, z0);
            r4_g[1] <= grad_dot(r3_h[1][3:0], x1, y0, z0);
            r4_g[2] <= grad_dot(r3_h[2][3:0], x0, y1, z0);
            r4_g[3] <= grad_dot(r3_h[3][3:0], x1, y1, z0);
            r4_g[4] <= grad_dot(r3_h[4][3:0], x0, y0, z1);
            r4_g[5] <= grad_dot(r3_h[5][3:0], x1, y0, z1);
            r4_g[6] <= grad_dot(r3_h[6][3:0], x0, y1, z1);
            r4_g[7] <= grad_dot(r3_h[7][3:0], x1, y1, z1);
        end
    end

    // Stage 5: fade clamp, differences for the x blends.
    t_frac r5_w [3];
    t_val  r5_p [4];
    t_val  r5_d [4];
    logic signed [24:0] fs [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            fs[k] = 25'(r4_fp[k] >>> 16);
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                if (fs[k] > 25'sd65535) begin
                    r5_w[k] <= 16'hFFFF;
                end else if (fs[k] < 25'sd0) begin
                    r5_w[k] <= 16'd0;
                end else begin
                    r5_w[k] <= fs[k][15:0];
                end
            end
            for (int j = 0; j < 4; j++) begin
                r5_p[j] <= r4_g[2*j];
                r5_d[j] <= r4_g[2*j+1] - r4_g[2*j];
            end
        end
    end

    // Stage 6: x blends.
    t_frac r6_v, r6_w;
    t_val  r6_l [4];
    logic signed [37:0] px [4];
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            px[j] = $signed({2'd0, r5_w[0]}) * 38'(r5_d[j]);
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r6_v <= r5_w[1];
            r6_w <= r5_w[2];
            for (int j = 0; j < 4; j++) begin
                r6_l[j] <= r5_p[j] + 20'(px[j] >>> 16);
            end
        end
    end

    // Stage 7: y differences.  Stage 8: y blends.
    t_frac r7_v, r7_w;
    t_val  r7_p [2];
    t_val  r7_d [2];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r7_v <= r6_v;
            r7_w <= r6_w;
            r7_p[0] <= r6_l[0];
            r7_d[0] <= r6_l[1] - r6_l[0];
            r7_p[1] <= r6_l[2];
            r7_d[1] <= r6_l[3] - r6_l[2];
        end
    end

    t_frac r8_w;
    t_val  r8_m [2];
    logic signed [37:0] py [2];
    always_comb begin
        for (int j = 0; j < 2; j++) begin
            py[j] = $signed({2'd0, r7_v}) * 38'(r7_d[j]);
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r8_w <= r7_w;
            for (int j = 0; j < 2; j++) begin
                r8_m[j] <= r7_p[j] + 20'(py[j] >>> 16);
            end
        end
    end

    // Stage 9: z difference.  Stage 10: z blend and saturation.
    t_frac r9_w;
    t_val  r9_p, r9_d;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r9_w <= r8_w;
            r9_p <= r8_m[0];
            r9_d <= r8_m[1] - r8_m[0];
        end
    end

    logic signed [37:0] pz;
    logic signed [21:0] rz;
    assign pz = $signed({2'd0, r9_w}) * 38'(r9_d);
    assign rz = 22'(r9_p) + 22'(pz >>> 16);
    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (rz > 22'sd131071) begin
                o_noise_value <= 18'sd131071;
            end else if (rz < -22'sd131072) begin
                o_noise_value <= 18'sh20000;
            end else begin
                o_noise_value <= rz[17:0];
            end
        end
    end

    `PN_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready,
        o_valid && $stable(o_noise_value), "stalled output word changed")
    `PN_ASSERT_IMPL(a_ready, i_clk, i_rst_n, !o_valid, o_ready,
        "pipeline stalled with no output word waiting")
    `PN_ASSERT_NEXT(a_flow, i_clk, i_rst_n, i_valid && o_ready, r_vld[0],
        "accepted word lost at pipeline entry")
endmodule
`default_nettype wire

[tb/tb_perlin_noise_3d.sv]
// Testbench for the 3D noise pipeline: queued stimulus, a computed expectation per point, output checks.
`timescale 1ns / 1ps
module tb_perlin_noise_3d;
    import pn3d_pkg::*;

    localparam int FB = 16;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    logic signed [31:0] i_coord_x = '0;
    logic signed [31:0] i_coord_y = '0;
    logic signed [31:0] i_coord_z = '0;
    wire o_ready;
    wire o_valid;
    wire signed [17:0] o_noise_value;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } t_point;

    t_point pending_points[$];
    logic signed [17:0] noise_expected[$];
    int mismatches = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_sender = 1'b0;

    perlin_noise_3d #(.FRAC_BITS(FB)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_coord_x(i_coord_x), .i_coord_y(i_coord_y), .i_coord_z(i_coord_z),
        .o_valid(o_valid), .i_ready(i_ready), .o_noise_value(o_noise_value)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic longint fl16(longint v);
        return v >>> 16;
    endfunction

    function automatic longint fade16(longint f);
        longint t2, t3, a, b, r;
        t2 = fl16(f * f);
        t3 = fl16(t2 * f);
        a = 6 * f - 15 * 65536;
        b = fl16(a * f) + 10 * 65536;
        r = fl16(t3 * b);
        if (r > 65535) r = 65535;
        if (r < 0) r = 0;
        return r;
    endfunction

    function automatic longint mix16(longint p, longint q, longint t);
        return p + fl16(t * (q - p));
    endfunction

    function automatic longint corner_dot(logic [7:0] h, longint x, longint y, longint z);
        logic [3:0] c;
        longint u, v;
        c = h[3:0];
        u = (c < 8) ? x : y;
        v = (c < 4) ? y : ((c == 12 || c == 14) ? x : z);
        return (c[0] ? -u : u) + (c[1] ? -v : v);
    endfunction

    function automatic logic [7:0] hash(int i);
        logic [7:0] k;
        k = i[7:0];
        return PERM[k];
    endfunction

    function automatic logic signed [17:0] noise_of(t_point p);
        logic [31:0] raw[3];
        int lat[3];
        longint f[3], g[3], fd[3];
        int a, b, aa, ab, ba, bb;
        longint l00, l10, l01, l11, m0, m1, r;
        logic [31:0] fr;
        raw[0] = p.x; raw[1] = p.y; raw[2] = p.z;
        for (int k = 0; k < 3; k++) begin
            lat[k] = (raw[k] >> FB) & 8'hFF;
            fr = raw[k] & ((32'd1 << FB) - 1);
            if (FB >= 16) fr = fr >> (FB - 16);
            else fr = fr << (16 - FB);
            f[k] = fr & 32'hFFFF;
            g[k] = f[k] - 65536;
            fd[k] = fade16(f[k]);
        end
        a = hash(lat[0]);
        b = hash(lat[0] + 1);
        aa = hash(a + lat[1]);
        ab = hash(a + lat[1] + 1);
        ba = hash(b + lat[1]);
        bb = hash(b + lat[1] + 1);
        l00 = mix16(corner_dot(hash(aa + lat[2]), f[0], f[1], f[2]),
                    corner_dot(hash(ba + lat[2]), g[0], f[1], f[2]), fd[0]);
        l10 = mix16(corner_dot(hash(ab + lat[2]), f[0], g[1], f[2]),
                    corner_dot(hash(bb + lat[2]), g[0], g[1], f[2]), fd[0]);
        l01 = mix16(corner_dot(hash(aa + lat[2] + 1), f[0], f[1], g[2]),
                    corner_dot(hash(ba + lat[2] + 1), g[0], f[1], g[2]), fd[0]);
        l11 = mix16(corner_dot(hash(ab + lat[2] + 1), f[0], g[1], g[2]),
                    corner_dot(hash(bb + lat[2] + 1), g[0], g[1], g[2]), fd[0]);
        m0 = mix16(l00, l10, fd[1]);
        m1 = mix16(l01, l11, fd[1]);
        r = mix16(m0, m1, fd[2]);
        if (r > 131071) r = 131071;
        if (r < -131072) r = -131072;
        return r[17:0];
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return {{16{1'b0}}, 16'($urandom)} - 32'h8000;
            2: return {8'($urandom), 24'($urandom)} ^ {32{$urandom_range(0, 1) == 1}};
            default: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
        endcase
    endfunction

    // Sender: the next word goes out once the previous one is taken, unless the sender is held or randomly idles.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || o_ready) begin
                if (i_valid) noise_expected.push_back(
                    noise_of({i_coord_x, i_coord_y, i_coord_z}));
                if (pending_points.size() > 0 && !hold_sender &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                    i_valid <= 1'b1;
                    {i_coord_x, i_coord_y, i_coord_z} <= pending_points.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (noise_expected.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: got %0d", o_noise_value);
                end else if (noise_expected[0] !== o_noise_value) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("noise mismatch: expected %0d got %0d",
                                 noise_expected[0], o_noise_value);
                    void'(noise_expected.pop_front());
                end else begin
                    void'(noise_expected.pop_front());
                end
            end
            i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic wait_drained();
        while (pending_points.size() > 0 || i_valid || noise_expected.size() > 0)
            @(negedge i_clk);
    endtask

    task automatic queue_random(int n);
        for (int i = 0; i < n; i++)
            pending_points.push_back({rand_coord(), rand_coord(), rand_coord()});
    endtask

    initial begin
        logic [31:0] edges[6];
        edges = '{32'h0, 32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h0000FFFF, 32'hFFFF0000};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int i = 0; i < 6; i++)
            pending_points.push_back({edges[i], edges[(i + 1) % 6], edges[(i + 3) % 6]});
        for (int i = 0; i < 16; i++)
            pending_points.push_back({32'(i) << 16 | 32'h8000,
                                      32'(255 - i) << 16 | 32'h4000, 32'h00FF_C000});
        wait_drained();
        hold_sender = 1'b1;
        queue_random(20);
        repeat (20) @(posedge i_clk);
        hold_sender = 1'b0;
        queue_random(120);
        wait_drained();
        send_idle_pct = 48;
        queue_random(120);
        wait_drained();
        send_idle_pct = 0; recv_stall_pct = 48;
        queue_random(120);
        wait_drained();
        send_idle_pct = 29; recv_stall_pct = 29;
        queue_random(120);
        wait_drained();
        repeat (3 * STAGES) @(posedge i_clk);
        if (mismatches == 0 && noise_expected.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
